>>> rtl/assert_macros.svh
// Assertion helpers for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [7:0][31:0] hash_t;

  localparam int unsigned ROUNDS     = 64;
  localparam int unsigned BLOCK_WORDS = 16;

  localparam logic [3:0] LEN_SLOT  = 4'd14;
  localparam logic [3:0] LAST_SLOT = 4'd15;
  localparam word_t      PAD_WORD  = 32'h8000_0000;

  // Element 0 holds H0.
  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic start;   // window is full, begin a block
    logic load;    // shift a message word into the window
    logic reinit;  // return the chaining words to their initial values
  } cmp_ctrl_t;

  typedef struct packed {
    logic done;    // chaining words take their new values at this edge
  } cmp_stat_t;

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/sha256_if.sv
`default_nettype none

interface sha256_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  bytes_valid;
  logic        last_word;

  modport source (output valid, output message_word, output bytes_valid,
                  output last_word, input ready);
  modport sink   (input valid, input message_word, input bytes_valid,
                  input last_word, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;

  modport source (output valid, output digest_word, output digest_last,
                  input ready);
  modport sink   (input valid, input digest_word, input digest_last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/sha256_sched.sv
`default_nettype none

// Sixteen-word message schedule window. Words enter at the top and move down
// one place per load or per round, so the current round always reads slot 0.
module sha256_sched
  import sha256_pkg::*;
(
  input  wire   clk_i,
  input  wire   load_i,
  input  wire   step_i,
  input  word_t word_i,
  output word_t w_o
);

  word_t win_q [BLOCK_WORDS];
  word_t next_w;

  assign next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
  assign w_o    = win_q[0];

  always_ff @(posedge clk_i) begin
    if (load_i || step_i) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[BLOCK_WORDS-1] <= load_i ? word_i : next_w;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sha256_compress.sv
`default_nettype none

// One SHA-256 round per cycle for all 64 rounds, then an add state that adds the
// working words into the chaining words.
module sha256_compress
  import sha256_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  cmp_ctrl_t ctrl_i,
  input  word_t     load_word_i,
  output cmp_stat_t stat_o,
  output hash_t     hash_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_ADD   = 3'b100
  } cmp_state_e;

  cmp_state_e state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  hash_t      chain_q, chain_d;
  hash_t      work_q, work_d;
  word_t      w_cur;
  word_t      t1, t2;

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .load_i (ctrl_i.load),
    .step_i (state_q == C_ROUND),
    .word_i (load_word_i),
    .w_o    (w_cur)
  );

  // Working words: element 0 is a, element 7 is h.
  assign t1 = work_q[7] + big_sigma1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + K_TABLE[rnd_q] + w_cur;
  assign t2 = big_sigma0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    chain_d = chain_q;
    work_d  = work_q;
    case (state_q)
      C_IDLE: begin
        if (ctrl_i.start) begin
          work_d  = chain_q;
          rnd_d   = '0;
          state_d = C_ROUND;
        end
      end
      C_ROUND: begin
        work_d[7] = work_q[6];
        work_d[6] = work_q[5];
        work_d[5] = work_q[4];
        work_d[4] = work_q[3] + t1;
        work_d[3] = work_q[2];
        work_d[2] = work_q[1];
        work_d[1] = work_q[0];
        work_d[0] = t1 + t2;
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == 6'(ROUNDS - 1)) begin
          state_d = C_ADD;
        end
      end
      C_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
    if (ctrl_i.reinit) begin
      chain_d = INIT_HASH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      chain_q <= INIT_HASH;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      chain_q <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign stat_o.done = (state_q == C_ADD);
  assign hash_o      = chain_q;

endmodule

`default_nettype wire

>>> rtl/sha256_digest.sv
`default_nettype none

// Holds a finished digest and hands it out one word at a time, so the
// hashing side can start on the next message while the digest drains.
module sha256_digest
  import sha256_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   load_i,
  input  hash_t hash_i,
  output logic  busy_o,
  sha256_out_if.source out_o
);

  hash_t      buf_q;
  logic [2:0] cnt_q;
  logic       busy_q;
  logic       take;

  assign take = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (take) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= hash_i;
    end else if (take) begin
      buf_q <= {32'd0, buf_q[7:1]};
    end
  end

  assign busy_o            = busy_q;
  assign out_o.valid       = busy_q;
  assign out_o.digest_word = buf_q[0];
  assign out_o.digest_last = (cnt_q == 3'd7);

endmodule

`default_nettype wire

>>> rtl/sha256_hash_engine.sv
`default_nettype none

// Channel   Dir  Payload                                  Handshake
// msg_i     in   message_word[31:0] bytes_valid[2:0] last  valid/ready
// dig_o     out  digest_word[31:0] digest_last            valid/ready
//
// A message word that does not complete a block is accepted in the idle state.
// The word that fills a block starts the rounds and the final add on the
// round unit; msg_i.ready stays low during that time.
// The last word adds fill words and one or two block compressions, then
// the FIN state moves the digest into the output buffer once it is free.
// Reset is asynchronous and active low and restores the initial hash values.
// A stalled dig_o holds its word; a new message may be hashed meanwhile, and
// its digest waits until the previous one has fully drained.
module sha256_hash_engine
  import sha256_pkg::*;
(
  input  wire clk_i,
  input  wire rst_ni,
  sha256_in_if.sink    msg_i,
  sha256_out_if.source dig_o
);

  // Sequencer states. PAD pushes pad, zero fill and length words into the
  // window, one per cycle. COMP waits on the round unit. FIN hands the digest
  // to the output buffer.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_FIN  = 4'b1000
  } seq_state_e;

  seq_state_e  state_q, state_d;
  logic [3:0]  slot_q, slot_d;
  logic [63:0] bits_q, bits_d;
  logic        pad_q, pad_d;     // a whole pad word still has to go in
  logic        len_q, len_d;     // high length word is already in
  logic        fin_q, fin_d;     // the message is being closed

  logic      acc;
  logic      push_en;
  word_t     push_w;
  word_t     keep;
  word_t     pad_bits;
  cmp_ctrl_t cmp_ctrl;
  cmp_stat_t cmp_stat;
  hash_t     hash;
  logic      dig_busy;
  logic      dig_load;

  assign acc         = msg_i.valid && msg_i.ready;
  assign msg_i.ready = (state_q == S_IDLE);

  // Mask for the valid leading bytes of a short last word, and the pad bit
  // right after them.
  always_comb begin
    case (msg_i.bytes_valid[1:0])
      2'd0: begin
        keep     = 32'h0000_0000;
        pad_bits = 32'h8000_0000;
      end
      2'd1: begin
        keep     = 32'hff00_0000;
        pad_bits = 32'h0080_0000;
      end
      2'd2: begin
        keep     = 32'hffff_0000;
        pad_bits = 32'h0000_8000;
      end
      2'd3: begin
        keep     = 32'hffff_ff00;
        pad_bits = 32'h0000_0080;
      end
      default: begin
        keep     = 32'h0000_0000;
        pad_bits = 32'h8000_0000;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    bits_d   = bits_q;
    pad_d    = pad_q;
    len_d    = len_q;
    fin_d    = fin_q;
    push_en  = 1'b0;
    push_w   = '0;
    dig_load = 1'b0;
    cmp_ctrl = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          push_en = 1'b1;
          if (!msg_i.last_word || msg_i.bytes_valid[2]) begin
            // A full word; counts of five and more on the last word act as four.
            push_w = msg_i.message_word;
            bits_d = bits_q + 64'd32;
          end else begin
            push_w = (msg_i.message_word & keep) | pad_bits;
            bits_d = bits_q + {59'd0, msg_i.bytes_valid[1:0], 3'd0};
          end
          if (msg_i.last_word) begin
            fin_d = 1'b1;
            pad_d = msg_i.bytes_valid[2];
          end
          if (slot_q == LAST_SLOT) begin
            state_d = S_COMP;
          end else if (msg_i.last_word) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        push_en = 1'b1;
        if (pad_q) begin
          push_w = PAD_WORD;
          pad_d  = 1'b0;
        end else if (len_q) begin
          push_w = bits_q[31:0];
        end else if (slot_q == LEN_SLOT) begin
          push_w = bits_q[63:32];
          len_d  = 1'b1;
        end else begin
          push_w = '0;
        end
        if (slot_q == LAST_SLOT) begin
          state_d = S_COMP;
        end
      end
      S_COMP: begin
        if (cmp_stat.done) begin
          if (!fin_q) begin
            state_d = S_IDLE;
          end else if (len_q) begin
            state_d = S_FIN;
          end else begin
            state_d = S_PAD;
          end
        end
      end
      S_FIN: begin
        if (!dig_busy) begin
          dig_load        = 1'b1;
          cmp_ctrl.reinit = 1'b1;
          bits_d          = '0;
          fin_d           = 1'b0;
          len_d           = 1'b0;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmp_ctrl.load  = push_en;
    cmp_ctrl.start = push_en && (slot_q == LAST_SLOT);
  end

  assign slot_d = push_en ? slot_q + 4'd1 : slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      bits_q  <= '0;
      pad_q   <= 1'b0;
      len_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      bits_q  <= bits_d;
      pad_q   <= pad_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
    end
  end

  sha256_compress u_compress (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (cmp_ctrl),
    .load_word_i (push_w),
    .stat_o      (cmp_stat),
    .hash_o      (hash)
  );

  sha256_digest u_digest (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (dig_load),
    .hash_i (hash),
    .busy_o (dig_busy),
    .out_o  (dig_o)
  );

endmodule

`default_nettype wire

>>> rtl/sha256_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sha256_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_last_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [31:0] out_word_i,
  input wire        out_last_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  `SHA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i) && $stable(out_last_i), "stalled digest word changed")
  `SHA_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, in_acc && in_last_i, !in_ready_i, "input ready right after a last word")
  `SHA_ASSERT_NEXT(a_gap_after_digest, clk_i, rst_ni, out_acc && out_last_i, !out_valid_i, "digest words follow the final one without a gap")
  `SHA_ASSERT_SAME(a_first_not_last, clk_i, rst_ni, $rose(out_valid_i), !out_last_i, "digest starts on its final word")

endmodule

bind sha256_hash_engine sha256_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (msg_i.valid),
  .in_ready_i  (msg_i.ready),
  .in_last_i   (msg_i.last_word),
  .out_valid_i (dig_o.valid),
  .out_ready_i (dig_o.ready),
  .out_word_i  (dig_o.digest_word),
  .out_last_i  (dig_o.digest_last)
);

`default_nettype wire
